// File: sv/adfgx_pkg.sv
// ----------------------------------------------------------------------------
// adfgx_pkg
// types, command codes and letter tables shared by the adfgx decrypt unit
// ----------------------------------------------------------------------------
package adfgx_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DIVK,
		ST_RANK_LD,
		ST_RANK_CMP,
		ST_START_LD,
		ST_START_CMP,
		ST_WALK_ADDR,
		ST_WALK_DATA,
		ST_SUM,
		ST_SUM_LAST,
		ST_DIVQ
	} state_t;

	localparam logic [1:0] FUNC_KEY     = 2'd0;
	localparam logic [1:0] FUNC_CIPHER  = 2'd1;
	localparam logic [1:0] FUNC_DECRYPT = 2'd2;
	localparam logic [1:0] FUNC_READ    = 2'd3;

	localparam logic REG_KEY_LENGTH = 1'b0;
	localparam logic REG_PAIR_COUNT = 1'b1;

	localparam logic [2:0] SYM_MAX    = 3'd4;
	localparam logic [4:0] CODE_MAX   = 5'd24;
	localparam logic [4:0] CODE_SKIPJ = 5'd9;
	localparam int         FRAC_BITS  = 11;
	localparam logic [4:0] IOC_SCALE  = 5'd25;

	// {valid, symbol}
	function automatic logic [3:0] symbol_of(input logic [7:0] ch);
		logic [3:0] r;
		case (ch)
			8'h41:   r = 4'b1_000;
			8'h44:   r = 4'b1_001;
			8'h46:   r = 4'b1_010;
			8'h47:   r = 4'b1_011;
			8'h58:   r = 4'b1_100;
			default: r = 4'b0_000;
		endcase
		return r;
	endfunction

	// square order without j
	function automatic logic [7:0] square_letter(input logic [4:0] code);
		logic [7:0] r;
		if (code > CODE_MAX) begin
			r = 8'h41;
		end else if (code < CODE_SKIPJ) begin
			r = 8'h41 + 8'(code);
		end else begin
			r = 8'h42 + 8'(code);
		end
		return r;
	endfunction

endpackage

// File: sv/adfgx_ram.sv
// ----------------------------------------------------------------------------
// adfgx_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module adfgx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/adfgx_decrypt_with_coincidence_index_unit.sv
// ----------------------------------------------------------------------------
// adfgx_decrypt_with_coincidence_index_unit
// adfgx key/cipher store, columnar untransposition, polybius mapping and
// index of coincidence over one shared restoring divider and a sequencer
// ----------------------------------------------------------------------------
// key and cipher loads: result strobe in the cycle after the beat, busy stays low
// plaintext read: result registered out of the read state after the beat, busy for one cycle
// decrypt: run time grows with the columns k and the pairs p, and is set
//   by the bit-serial divider, the column ranking loops and the cipher ram port
// one command at a time; results are never stalled
// reset clears control state; key, cipher and plaintext stores are undefined
// ----------------------------------------------------------------------------
module adfgx_decrypt_with_coincidence_index_unit #(
	parameter int MAX_KEY    = 16,
	parameter int MAX_CIPHER = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [8:0]  index,
	input  logic [7:0]  value,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [7:0]  letter,
	output logic [4:0]  plain_code,
	output logic [15:0] coincidence_sum,
	output logic [15:0] ioc_fixed,
	output logic        rejected
);

	localparam int PAIRS = MAX_CIPHER / 2;
	localparam int KW    = $clog2(MAX_KEY);
	localparam int KLW   = $clog2(MAX_KEY + 1);
	localparam int CW    = $clog2(MAX_CIPHER);
	localparam int PW    = $clog2(PAIRS);
	localparam int DW    = 34;
	localparam int RW    = 19;
	localparam int SW    = 18;

	adfgx_pkg::state_t state_q, state_d;

	logic [4:0]  key_length_q;
	logic [8:0]  pair_count_q;
	logic [7:0]  key_q [MAX_KEY];
	logic [KW-1:0] rank_q [MAX_KEY];
	logic [9:0]  start_q [MAX_KEY];
	logic [8:0]  count_q [25];

	logic [KLW-1:0] eff_k;
	logic [8:0]     eff_p;
	logic [KW-1:0]  k_last;
	logic [9:0]     n_sym;

	logic [KW-1:0] a_q, b_q, col_q;
	logic [KW-1:0] r_q, cur_rank_q, extra_q;
	logic [7:0]    cur_key_q;
	logic [9:0]    s_q, base_q, row_q;
	logic [8:0]    i_q;
	logic          h_q;
	logic [2:0]    sym0_q;
	logic          at_ok_q;
	logic [4:0]    sa_q;
	logic [SW-1:0] prod_q, sum_q, den_q;
	logic          pv_q;
	logic          rd_ok_q;

	logic [DW-1:0] div_dvd_q;
	logic [RW-1:0] div_rem_q;
	logic [SW-1:0] div_dvs_q;
	logic [5:0]    div_cnt_q;
	logic [RW-1:0] div_shift, div_rem_n;
	logic [DW-1:0] div_dvd_n;
	logic          div_ge, div_last;

	logic          done_q, rej_q;
	logic [7:0]    letter_q;
	logic [4:0]    code_q;
	logic [15:0]   csum_q, ioc_q;

	logic          accept;
	logic [7:0]    key_rd;
	logic [KW-1:0] rank_rd;
	logic          key_less;
	logic [KW-1:0] r_n;
	logic [9:0]    s_n;
	logic [10:0]   at;
	logic [3:0]    sym_in;
	logic          key_ok, cip_ok, rd_ok;
	logic [2:0]    sym_c;
	logic [4:0]    code_c;
	logic [8:0]    cnt_rd;
	logic [SW-1:0] sum_fin;

	logic          cip_we;
	logic [CW-1:0] cip_waddr, cip_raddr;
	logic [2:0]    cip_rdata;
	logic          pl_we;
	logic [PW-1:0] pl_raddr;
	logic [4:0]    pl_rdata;

	// effective register values
	always_comb begin
		if (key_length_q == 5'd0) begin
			eff_k = KLW'(1);
		end else if (6'(key_length_q) > 6'(MAX_KEY)) begin
			eff_k = KLW'(MAX_KEY);
		end else begin
			eff_k = KLW'(key_length_q);
		end
		if (pair_count_q == 9'd0) begin
			eff_p = 9'd1;
		end else if (13'(pair_count_q) > 13'(PAIRS)) begin
			eff_p = 9'(PAIRS);
		end else begin
			eff_p = pair_count_q;
		end
	end

	assign k_last = KW'(eff_k - KLW'(1));
	assign n_sym  = {eff_p, 1'b0};
	assign accept = start && (state_q == adfgx_pkg::ST_IDLE);

	assign sym_in = adfgx_pkg::symbol_of(value);
	assign key_ok = 13'(index) < 13'(MAX_KEY);
	assign cip_ok = (13'(index) < 13'(MAX_CIPHER)) && sym_in[3];
	assign rd_ok  = (index < eff_p) && (13'(index) < 13'(PAIRS));

	// shared divider step
	assign div_shift = {div_rem_q[RW-2:0], div_dvd_q[DW-1]};
	assign div_ge    = div_shift >= {1'b0, div_dvs_q};
	assign div_rem_n = div_ge ? div_shift - {1'b0, div_dvs_q} : div_shift;
	assign div_dvd_n = {div_dvd_q[DW-2:0], div_ge};
	assign div_last  = div_cnt_q == 6'(DW - 1);

	// ranking and start compare
	assign key_rd   = key_q[(state_q == adfgx_pkg::ST_RANK_LD) ? a_q : b_q];
	assign key_less = (key_rd < cur_key_q) || ((key_rd == cur_key_q) && (b_q < a_q));
	assign r_n      = r_q + KW'(key_less);
	assign rank_rd  = rank_q[(state_q == adfgx_pkg::ST_START_LD) ? a_q : b_q];
	assign s_n      = (rank_rd < cur_rank_q) ? s_q + base_q + 10'(b_q < extra_q) : s_q;

	// cipher walk
	assign at     = 11'(start_q[col_q]) + 11'(row_q);
	assign sym_c  = (at_ok_q && (cip_rdata <= adfgx_pkg::SYM_MAX)) ? cip_rdata : 3'd0;
	assign code_c = 5'(sym0_q) * 5'd5 + 5'(sym_c);

	assign cnt_rd  = count_q[sa_q];
	assign sum_fin = sum_q + prod_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			adfgx_pkg::ST_IDLE: begin
				if (start) begin
					if (func == adfgx_pkg::FUNC_DECRYPT) begin
						state_d = adfgx_pkg::ST_DIVK;
					end else if (func == adfgx_pkg::FUNC_READ) begin
						state_d = adfgx_pkg::ST_READ;
					end
				end
			end
			adfgx_pkg::ST_READ:      state_d = adfgx_pkg::ST_IDLE;
			adfgx_pkg::ST_DIVK: begin
				if (div_last) state_d = adfgx_pkg::ST_RANK_LD;
			end
			adfgx_pkg::ST_RANK_LD:   state_d = adfgx_pkg::ST_RANK_CMP;
			adfgx_pkg::ST_RANK_CMP: begin
				if (b_q == k_last) begin
					state_d = (a_q == k_last) ? adfgx_pkg::ST_START_LD : adfgx_pkg::ST_RANK_LD;
				end
			end
			adfgx_pkg::ST_START_LD:  state_d = adfgx_pkg::ST_START_CMP;
			adfgx_pkg::ST_START_CMP: begin
				if (b_q == k_last) begin
					state_d = (a_q == k_last) ? adfgx_pkg::ST_WALK_ADDR : adfgx_pkg::ST_START_LD;
				end
			end
			adfgx_pkg::ST_WALK_ADDR: state_d = adfgx_pkg::ST_WALK_DATA;
			adfgx_pkg::ST_WALK_DATA: begin
				if (h_q && (i_q == eff_p - 9'd1)) begin
					state_d = adfgx_pkg::ST_SUM;
				end else begin
					state_d = adfgx_pkg::ST_WALK_ADDR;
				end
			end
			adfgx_pkg::ST_SUM: begin
				if (sa_q == adfgx_pkg::CODE_MAX) state_d = adfgx_pkg::ST_SUM_LAST;
			end
			adfgx_pkg::ST_SUM_LAST: begin
				state_d = (den_q == '0) ? adfgx_pkg::ST_IDLE : adfgx_pkg::ST_DIVQ;
			end
			adfgx_pkg::ST_DIVQ: begin
				if (div_last) state_d = adfgx_pkg::ST_IDLE;
			end
			default:                 state_d = adfgx_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		busy      = state_q != adfgx_pkg::ST_IDLE;
		cip_we    = accept && (func == adfgx_pkg::FUNC_CIPHER) && cip_ok;
		cip_waddr = CW'(index);
		cip_raddr = CW'(at);
		pl_we     = (state_q == adfgx_pkg::ST_WALK_DATA) && h_q;
		pl_raddr  = PW'(index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= adfgx_pkg::ST_IDLE;
			done_q       <= 1'b0;
			key_length_q <= 5'd1;
			pair_count_q <= 9'd1;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == adfgx_pkg::REG_KEY_LENGTH) begin
					key_length_q <= cfg_data[4:0];
				end else begin
					pair_count_q <= cfg_data;
				end
			end
			done_q <= (accept && (func == adfgx_pkg::FUNC_KEY ||
				func == adfgx_pkg::FUNC_CIPHER)) ||
				(state_q == adfgx_pkg::ST_READ) ||
				(state_q == adfgx_pkg::ST_SUM_LAST && den_q == '0) ||
				(state_q == adfgx_pkg::ST_DIVQ && div_last);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			adfgx_pkg::ST_IDLE: begin
				if (accept) begin
					letter_q <= '0;
					code_q   <= '0;
					csum_q   <= '0;
					ioc_q    <= '0;
					case (func)
						adfgx_pkg::FUNC_KEY: begin
							if (key_ok) key_q[KW'(index)] <= value;
							rej_q <= !key_ok;
						end
						adfgx_pkg::FUNC_CIPHER: begin
							rej_q <= !cip_ok;
						end
						adfgx_pkg::FUNC_DECRYPT: begin
							rej_q     <= 1'b0;
							div_dvd_q <= DW'(n_sym);
							div_rem_q <= '0;
							div_dvs_q <= SW'(eff_k);
							div_cnt_q <= '0;
							den_q     <= SW'(eff_p) * SW'(eff_p - 9'd1);
							a_q       <= '0;
							for (int c = 0; c < 25; c++) count_q[c] <= '0;
						end
						adfgx_pkg::FUNC_READ: begin
							rej_q   <= 1'b0;
							rd_ok_q <= rd_ok;
						end
						default: begin
							rej_q <= 1'b0;
						end
					endcase
				end
			end
			adfgx_pkg::ST_READ: begin
				if (rd_ok_q) begin
					code_q   <= (pl_rdata > adfgx_pkg::CODE_MAX) ? 5'd0 : pl_rdata;
					letter_q <= adfgx_pkg::square_letter(pl_rdata);
				end
				rej_q <= !rd_ok_q;
			end
			adfgx_pkg::ST_DIVK: begin
				div_cnt_q <= div_cnt_q + 6'd1;
				div_rem_q <= div_rem_n;
				div_dvd_q <= div_dvd_n;
				if (div_last) begin
					base_q  <= div_dvd_n[9:0];
					extra_q <= KW'(div_rem_n);
				end
			end
			adfgx_pkg::ST_RANK_LD: begin
				cur_key_q <= key_rd;
				b_q       <= '0;
				r_q       <= '0;
			end
			adfgx_pkg::ST_RANK_CMP: begin
				r_q <= r_n;
				b_q <= b_q + KW'(1);
				if (b_q == k_last) begin
					rank_q[a_q] <= r_n;
					a_q         <= (a_q == k_last) ? '0 : a_q + KW'(1);
				end
			end
			adfgx_pkg::ST_START_LD: begin
				cur_rank_q <= rank_rd;
				b_q        <= '0;
				s_q        <= '0;
			end
			adfgx_pkg::ST_START_CMP: begin
				s_q <= s_n;
				b_q <= b_q + KW'(1);
				if (b_q == k_last) begin
					start_q[a_q] <= s_n;
					a_q          <= a_q + KW'(1);
					col_q        <= '0;
					row_q        <= '0;
					i_q          <= '0;
					h_q          <= 1'b0;
				end
			end
			adfgx_pkg::ST_WALK_ADDR: begin
				at_ok_q <= 13'(at) < 13'(MAX_CIPHER);
				if (col_q == k_last) begin
					col_q <= '0;
					row_q <= row_q + 10'd1;
				end else begin
					col_q <= col_q + KW'(1);
				end
			end
			adfgx_pkg::ST_WALK_DATA: begin
				h_q <= !h_q;
				if (!h_q) begin
					sym0_q <= sym_c;
				end else begin
					count_q[code_c] <= count_q[code_c] + 9'd1;
					i_q             <= i_q + 9'd1;
					sa_q            <= '0;
					sum_q           <= '0;
					pv_q            <= 1'b0;
				end
			end
			adfgx_pkg::ST_SUM: begin
				if (pv_q) sum_q <= sum_fin;
				prod_q <= SW'(cnt_rd) * SW'((cnt_rd == 9'd0) ? 9'd0 : cnt_rd - 9'd1);
				pv_q   <= 1'b1;
				sa_q   <= sa_q + 5'd1;
			end
			adfgx_pkg::ST_SUM_LAST: begin
				sum_q     <= sum_fin;
				csum_q    <= sum_fin[15:0];
				ioc_q     <= 16'hFFFF;
				div_dvd_q <= {23'(sum_fin) * 23'(adfgx_pkg::IOC_SCALE),
					11'(0)};
				div_rem_q <= '0;
				div_dvs_q <= den_q;
				div_cnt_q <= '0;
			end
			adfgx_pkg::ST_DIVQ: begin
				div_cnt_q <= div_cnt_q + 6'd1;
				div_rem_q <= div_rem_n;
				div_dvd_q <= div_dvd_n;
				if (div_last) begin
					ioc_q <= (div_dvd_n[DW-1:16] != '0) ? 16'hFFFF : div_dvd_n[15:0];
				end
			end
			default: begin
				pv_q <= 1'b0;
			end
		endcase
	end

	adfgx_ram #(
		.WIDTH(3),
		.DEPTH(MAX_CIPHER)
	) u_cipher_ram (
		.clk  (clk),
		.we   (cip_we),
		.waddr(cip_waddr),
		.wdata(sym_in[2:0]),
		.raddr(cip_raddr),
		.rdata(cip_rdata)
	);

	adfgx_ram #(
		.WIDTH(5),
		.DEPTH(PAIRS)
	) u_plain_ram (
		.clk  (clk),
		.we   (pl_we),
		.waddr(PW'(i_q)),
		.wdata(code_c),
		.raddr(pl_raddr),
		.rdata(pl_rdata)
	);

	assign done            = done_q;
	assign letter          = letter_q;
	assign plain_code      = code_q;
	assign coincidence_sum = csum_q;
	assign ioc_fixed       = ioc_q;
	assign rejected        = rej_q;

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == adfgx_pkg::ST_WALK_DATA |-> $past(state_q) == adfgx_pkg::ST_WALK_ADDR)
		else $error("walk data without address beat");

	a_ioc_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && ioc_q != 16'd0 |->
		$past(state_q) == adfgx_pkg::ST_DIVQ || $past(state_q) == adfgx_pkg::ST_SUM_LAST)
		else $error("ioc result outside decrypt");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> code_q <= adfgx_pkg::CODE_MAX)
		else $error("plaintext code out of square");

endmodule

// File: sim/tb_adfgx_decrypt_with_coincidence_index_unit.sv
// ----------------------------------------------------------------------------
// tb_adfgx_decrypt_with_coincidence_index_unit
// self-checking bench: key and cipher loads, decrypts and plaintext reads in
// phases of register settings; every result is checked against a local model
// ----------------------------------------------------------------------------
module tb_adfgx_decrypt_with_coincidence_index_unit;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0] fn;
		logic [8:0] idx;
		logic [7:0] val;
	} cmd_t;

	typedef struct {
		logic [7:0]  letter;
		logic [4:0]  code;
		logic [15:0] csum;
		logic [15:0] ioc;
		logic        rej;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [8:0]  index;
	logic [7:0]  value;
	logic        cfg_we;
	logic        cfg_index;
	logic [8:0]  cfg_data;
	logic        done;
	logic [7:0]  letter;
	logic [4:0]  plain_code;
	logic [15:0] coincidence_sum;
	logic [15:0] ioc_fixed;
	logic        rejected;

	cmd_t    cmd_q[$];
	answer_t answer_q[$];
	int      errors;
	int      beats;

	// local copy of the block state
	logic [4:0] key_len_r;
	logic [8:0] pair_cnt_r;
	logic [7:0] key_mem[16];
	logic [2:0] sym_mem[512];
	logic [4:0] code_mem[256];

	adfgx_decrypt_with_coincidence_index_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .index(index), .value(value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .letter(letter), .plain_code(plain_code),
		.coincidence_sum(coincidence_sum), .ioc_fixed(ioc_fixed),
		.rejected(rejected)
	);

	always #2 clk = ~clk;

	function automatic int cols_used();
		if (key_len_r < 1) return 1;
		if (key_len_r > 16) return 16;
		return int'(key_len_r);
	endfunction

	function automatic int pairs_used();
		if (pair_cnt_r < 1) return 1;
		if (pair_cnt_r > 256) return 256;
		return int'(pair_cnt_r);
	endfunction

	function automatic logic [2:0] adfgx_sym(input logic [7:0] ch, output logic ok);
		ok = 1'b1;
		case (ch)
			8'h41: return 3'd0;
			8'h44: return 3'd1;
			8'h46: return 3'd2;
			8'h47: return 3'd3;
			8'h58: return 3'd4;
			default: begin
				ok = 1'b0;
				return 3'd0;
			end
		endcase
	endfunction

	function automatic answer_t predict_answer(input cmd_t c);
		answer_t a;
		logic ok;
		logic [2:0] s;
		int k, p, n, base, extra, sum, at, pos, sy0, sy1, cd;
		int rank[16];
		int colst[16];
		int cnt[25];
		longint den, q;
		string sq;
		sq = "ABCDEFGHIKLMNOPQRSTUVWXYZ";
		a = '{8'd0, 5'd0, 16'd0, 16'd0, 1'b0};
		case (c.fn)
			adfgx_pkg::FUNC_KEY: begin
				if (c.idx < 16) key_mem[c.idx] = c.val;
				else a.rej = 1'b1;
			end
			adfgx_pkg::FUNC_CIPHER: begin
				s = adfgx_sym(c.val, ok);
				if (ok) sym_mem[c.idx] = s;
				else a.rej = 1'b1;
			end
			adfgx_pkg::FUNC_DECRYPT: begin
				k = cols_used();
				p = pairs_used();
				n = 2 * p;
				base = n / k;
				extra = n % k;
				for (int x = 0; x < k; x++) begin
					rank[x] = 0;
					for (int y = 0; y < k; y++)
						if (key_mem[y] < key_mem[x] || (key_mem[y] == key_mem[x] && y < x))
							rank[x]++;
				end
				for (int x = 0; x < k; x++) begin
					colst[x] = 0;
					for (int y = 0; y < k; y++)
						if (rank[y] < rank[x]) colst[x] += base + (y < extra ? 1 : 0);
				end
				for (int x = 0; x < 25; x++) cnt[x] = 0;
				for (int i = 0; i < p; i++) begin
					pos = 2 * i;
					at = colst[pos % k] + pos / k;
					sy0 = at < 512 ? int'(sym_mem[at]) : 0;
					if (sy0 > 4) sy0 = 0;
					pos = 2 * i + 1;
					at = colst[pos % k] + pos / k;
					sy1 = at < 512 ? int'(sym_mem[at]) : 0;
					if (sy1 > 4) sy1 = 0;
					code_mem[i] = 5'(sy0 * 5 + sy1);
					cnt[sy0 * 5 + sy1]++;
				end
				sum = 0;
				for (int x = 0; x < 25; x++) sum += cnt[x] * (cnt[x] > 0 ? cnt[x] - 1 : 0);
				a.csum = 16'(sum);
				den = longint'(p) * longint'(p - 1);
				if (den == 0) begin
					a.ioc = 16'hffff;
				end else begin
					q = (longint'(sum) * 25 * 2048) / den;
					a.ioc = q > 65535 ? 16'hffff : 16'(q);
				end
			end
			default: begin
				if (c.idx < pairs_used()) begin
					cd = int'(code_mem[c.idx]);
					if (cd > 24) cd = 0;
					a.letter = sq[cd];
					a.code = 5'(cd);
				end else begin
					a.rej = 1'b1;
				end
			end
		endcase
		return a;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			func  <= adfgx_pkg::FUNC_KEY;
			index <= '0;
			value <= '0;
			beats <= 0;
		end else begin
			if (start && !busy) begin
				answer_q.push_back(predict_answer(cmd_q.pop_front()));
				beats <= beats + 1;
			end
			if (!(start && busy)) begin
				if (cmd_q.size() > 0 &&
				    ((beats > 200 && beats < 450) || $urandom_range(99) >= 12)) begin
					start <= 1'b1;
					func  <= cmd_q[0].fn;
					index <= cmd_q[0].idx;
					value <= cmd_q[0].val;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = answer_q.pop_front();
				if (letter !== e.letter) begin
					$error("letter: expected %0h, got %0h", e.letter, letter);
					errors++;
				end
				if (plain_code !== e.code) begin
					$error("plain_code: expected %0d, got %0d", e.code, plain_code);
					errors++;
				end
				if (coincidence_sum !== e.csum) begin
					$error("coincidence_sum: expected %0d, got %0d", e.csum, coincidence_sum);
					errors++;
				end
				if (ioc_fixed !== e.ioc) begin
					$error("ioc_fixed: expected %0d, got %0d", e.ioc, ioc_fixed);
					errors++;
				end
				if (rejected !== e.rej) begin
					$error("rejected: expected %0b, got %0b", e.rej, rejected);
					errors++;
				end
			end
		end
	end

	task automatic queue_cmd(input logic [1:0] fn, input int idx, input int val);
		cmd_q.push_back('{fn, 9'(idx), 8'(val)});
	endtask

	function automatic int good_letter();
		int t[5] = '{8'h41, 8'h44, 8'h46, 8'h47, 8'h58};
		return t[$urandom_range(4)];
	endfunction

	task automatic drain();
		while (cmd_q.size() > 0 || start || answer_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic ri, input int d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= 9'(d);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (ri == adfgx_pkg::REG_KEY_LENGTH) key_len_r = 5'(d);
		else pair_cnt_r = 9'(d);
	endtask

	// timeout
	initial begin
		#40ms;
		$display("tb_adfgx_decrypt_with_coincidence_index_unit: errors");
		$finish;
	end

	initial begin
		int klist[11] = '{1, 16, 0, 31, 3, 5, 1, 7, 2, 16, 4};
		int plist[11] = '{1, 40, 0, 511, 5, 7, 1, 20, 3, 9, 13};
		int p, r, nrand;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = adfgx_pkg::REG_KEY_LENGTH;
		cfg_data = '0;
		errors = 0;
		key_len_r = 5'd1;
		pair_cnt_r = 9'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 11; ph++) begin
			if (ph > 0) begin
				drain();
				write_reg(adfgx_pkg::REG_KEY_LENGTH, klist[ph]);
				write_reg(adfgx_pkg::REG_PAIR_COUNT, plist[ph]);
			end
			p = pairs_used();
			// fill key and every cipher symbol the decrypt walks
			for (int i = 0; i < 16; i++)
				queue_cmd(adfgx_pkg::FUNC_KEY, i, 8'h41 + $urandom_range(3));
			for (int i = 0; i < 2 * p; i++)
				queue_cmd(adfgx_pkg::FUNC_CIPHER, i, good_letter());
			queue_cmd(adfgx_pkg::FUNC_DECRYPT, $urandom_range(511), $urandom_range(255));
			if (ph == 0) begin
				queue_cmd(adfgx_pkg::FUNC_KEY, 16, 8'h41);
				queue_cmd(adfgx_pkg::FUNC_KEY, 511, 255);
				queue_cmd(adfgx_pkg::FUNC_KEY, 15, 0);
				queue_cmd(adfgx_pkg::FUNC_KEY, 0, 255);
				queue_cmd(adfgx_pkg::FUNC_CIPHER, 0, 8'h42);
				queue_cmd(adfgx_pkg::FUNC_CIPHER, 1, 0);
				queue_cmd(adfgx_pkg::FUNC_CIPHER, 1, 255);
				queue_cmd(adfgx_pkg::FUNC_CIPHER, 511, 8'h58);
				queue_cmd(adfgx_pkg::FUNC_CIPHER, 0, 8'h58);
				queue_cmd(adfgx_pkg::FUNC_CIPHER, 1, 8'h46);
				queue_cmd(adfgx_pkg::FUNC_DECRYPT, 0, 0);
				queue_cmd(adfgx_pkg::FUNC_READ, 0, 0);
				queue_cmd(adfgx_pkg::FUNC_READ, 1, 0);
				queue_cmd(adfgx_pkg::FUNC_READ, 255, 0);
				queue_cmd(adfgx_pkg::FUNC_READ, 511, 255);
			end
			nrand = (p == 256) ? 8 : 12;
			for (int j = 0; j < nrand; j++) begin
				r = $urandom_range(99);
				if (r < 30) begin
					if ($urandom_range(3) > 0)
						queue_cmd(adfgx_pkg::FUNC_CIPHER, $urandom_range(2 * p - 1),
							good_letter());
					else
						queue_cmd(adfgx_pkg::FUNC_CIPHER, $urandom_range(511),
							$urandom_range(255));
				end else if (r < 45) begin
					if ($urandom_range(3) > 0)
						queue_cmd(adfgx_pkg::FUNC_KEY, $urandom_range(15), $urandom_range(255));
					else
						queue_cmd(adfgx_pkg::FUNC_KEY, $urandom_range(511), $urandom_range(255));
				end else if (r < 57) begin
					queue_cmd(adfgx_pkg::FUNC_DECRYPT, $urandom_range(511), $urandom_range(255));
				end else begin
					if ($urandom_range(3) > 0)
						queue_cmd(adfgx_pkg::FUNC_READ, $urandom_range(p - 1), $urandom_range(255));
					else
						queue_cmd(adfgx_pkg::FUNC_READ, $urandom_range(511), $urandom_range(255));
				end
			end
		end
		drain();
		if (errors == 0) begin
			$display("tb_adfgx_decrypt_with_coincidence_index_unit: clean");
		end else begin
			$display("tb_adfgx_decrypt_with_coincidence_index_unit: errors");
		end
		$finish;
	end

endmodule
